FILE: rtl/ssh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssh_pkg: shared types, constants and microcode for the sweep homing block
// Holds field widths, opcode and result codes, the control word layout and
// the read-only microprogram that the sequencer steps through.
// ----------------------------------------------------------------------------
package ssh_pkg;

  // Field and register widths
  localparam int POS_BITS_DEF = 32;
  localparam int VAL_W        = 32;
  localparam int OP_W         = 2;
  localparam int KIND_W       = 2;
  localparam int REV_W        = 16;
  localparam int SW_W         = 14;
  localparam int PASS_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int REM_W        = REV_W + 1;
  localparam int SPAN_W       = 18;
  localparam int ARITH_W      = 34;
  localparam int ADDR_W       = 5;

  // Sweep count and the width in steps that a measurement must exceed
  localparam int SWEEPS    = 8;
  localparam int MIN_WIDTH = 10;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_REV_STEPS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IS_SECONDARY = 2'd2;

  localparam logic [REV_W-1:0] REV_STEPS_RST    = 16'd3200;
  localparam logic [SW_W-1:0]  SENSOR_WIDTH_RST = 14'd100;
  localparam logic             IS_SECONDARY_RST = 1'b1;

  // Input opcodes
  localparam logic [OP_W-1:0] OP_BEGIN  = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SETPOS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MOVE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CENTRE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_HOME   = 2'd3;

  // Datapath actions
  typedef enum logic [3:0] {
    A_NOP,
    A_FETCH,
    A_BEGIN,
    A_DIV_WAIT,
    A_FOLD,
    A_EMIT_FOLD,
    A_SPAN,
    A_EMIT_TARGET,
    A_PASS_INC,
    A_EDGE,
    A_EMIT_CENTRE,
    A_FINISH,
    A_QUIT
  } act_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_OP_BEGIN,
    C_SKIP,
    C_OP_SAMPLE,
    C_PASS_LT,
    C_WIDTH_BAD,
    C_MEAS_OK,
    C_REV_ZERO,
    C_PRIMARY
  } cond_t;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    act_t              act;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic              last;
    cond_t             cond;
    addr_t             target;
  } uword_t;

  typedef struct packed {
    uword_t word;
    logic   go;
  } ctl_t;

  typedef struct packed {
    logic in_fire;
    logic div_done;
    logic out_free;
    logic op_begin;
    logic op_sample;
    logic skip;
    logic pass_lt;
    logic width_bad;
    logic meas_ok;
    logic rev_zero;
    logic primary;
  } stat_t;

  typedef struct packed {
    logic [REV_W-1:0] rev_steps;
    logic [SW_W-1:0]  sensor_width;
    logic             is_secondary;
  } cfg_t;

  // Microprogram entry points
  localparam addr_t ADDR_FETCH    = 5'd0;
  localparam addr_t ADDR_DISPATCH = 5'd1;
  localparam addr_t ADDR_SKIP     = 5'd2;
  localparam addr_t ADDR_IS_SMP   = 5'd3;
  localparam addr_t ADDR_DONE     = 5'd4;
  localparam addr_t ADDR_FINAL    = 5'd5;
  localparam addr_t ADDR_FOUND    = 5'd6;
  localparam addr_t ADDR_FOUND_HM = 5'd7;
  localparam addr_t ADDR_QUIT     = 5'd8;
  localparam addr_t ADDR_NEXT     = 5'd9;
  localparam addr_t ADDR_SPAN     = 5'd10;
  localparam addr_t ADDR_TARGET   = 5'd11;
  localparam addr_t ADDR_SAMPLE   = 5'd12;
  localparam addr_t ADDR_MEAS     = 5'd13;
  localparam addr_t ADDR_SMP_END  = 5'd14;
  localparam addr_t ADDR_BEGIN    = 5'd15;
  localparam addr_t ADDR_DIV_WAIT = 5'd16;
  localparam addr_t ADDR_FOLD     = 5'd17;
  localparam addr_t ADDR_EMIT_FLD = 5'd18;

  function automatic uword_t uop(input act_t act, input logic emit,
                                 input logic [KIND_W-1:0] kind, input logic last,
                                 input cond_t cond, input addr_t target);
    uword_t w;
    w.act    = act;
    w.emit   = emit;
    w.kind   = kind;
    w.last   = last;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Control store: one word per step
  function automatic uword_t ucode_rom(input addr_t a);
    uword_t w;
    unique case (a)
      ADDR_FETCH:    w = uop(A_FETCH,       1'b0, KIND_SETPOS, 1'b0, C_NEVER,     ADDR_FETCH);
      ADDR_DISPATCH: w = uop(A_NOP,         1'b0, KIND_SETPOS, 1'b0, C_OP_BEGIN,  ADDR_BEGIN);
      ADDR_SKIP:     w = uop(A_NOP,         1'b0, KIND_SETPOS, 1'b0, C_SKIP,      ADDR_FETCH);
      ADDR_IS_SMP:   w = uop(A_NOP,         1'b0, KIND_SETPOS, 1'b0, C_OP_SAMPLE, ADDR_SAMPLE);
      ADDR_DONE:     w = uop(A_NOP,         1'b0, KIND_SETPOS, 1'b0, C_PASS_LT,   ADDR_NEXT);
      ADDR_FINAL:    w = uop(A_NOP,         1'b0, KIND_SETPOS, 1'b0, C_WIDTH_BAD, ADDR_QUIT);
      ADDR_FOUND:    w = uop(A_EMIT_CENTRE, 1'b1, KIND_CENTRE, 1'b0, C_NEVER,     ADDR_FETCH);
      ADDR_FOUND_HM: w = uop(A_FINISH,      1'b1, KIND_HOME,   1'b1, C_ALWAYS,    ADDR_FETCH);
      ADDR_QUIT:     w = uop(A_QUIT,        1'b1, KIND_HOME,   1'b1, C_ALWAYS,    ADDR_FETCH);
      ADDR_NEXT:     w = uop(A_PASS_INC,    1'b0, KIND_SETPOS, 1'b0, C_NEVER,     ADDR_FETCH);
      ADDR_SPAN:     w = uop(A_SPAN,        1'b0, KIND_SETPOS, 1'b0, C_NEVER,     ADDR_FETCH);
      ADDR_TARGET:   w = uop(A_EMIT_TARGET, 1'b1, KIND_MOVE,   1'b1, C_ALWAYS,    ADDR_FETCH);
      ADDR_SAMPLE:   w = uop(A_EDGE,        1'b0, KIND_SETPOS, 1'b0, C_NEVER,     ADDR_FETCH);
      ADDR_MEAS:     w = uop(A_NOP,         1'b0, KIND_SETPOS, 1'b0, C_MEAS_OK,   ADDR_FOUND);
      ADDR_SMP_END:  w = uop(A_NOP,         1'b0, KIND_SETPOS, 1'b0, C_ALWAYS,    ADDR_FETCH);
      ADDR_BEGIN:    w = uop(A_BEGIN,       1'b0, KIND_SETPOS, 1'b0, C_REV_ZERO,  ADDR_FOLD);
      ADDR_DIV_WAIT: w = uop(A_DIV_WAIT,    1'b0, KIND_SETPOS, 1'b0, C_NEVER,     ADDR_FETCH);
      ADDR_FOLD:     w = uop(A_FOLD,        1'b0, KIND_SETPOS, 1'b0, C_PRIMARY,   ADDR_SPAN);
      ADDR_EMIT_FLD: w = uop(A_EMIT_FOLD,   1'b1, KIND_SETPOS, 1'b0, C_ALWAYS,    ADDR_SPAN);
      default:       w = uop(A_NOP,         1'b0, KIND_SETPOS, 1'b0, C_ALWAYS,    ADDR_FETCH);
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/ssh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssh_if: input and result channels of the sweep homing block
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ssh_item_if;
  logic                            valid;
  logic                            ready;
  logic [ssh_pkg::OP_W-1:0]        op;
  logic signed [ssh_pkg::VAL_W-1:0] position;
  logic                            sensor;

  modport source (output valid, output op, output position, output sensor, input ready);
  modport sink   (input valid, input op, input position, input sensor, output ready);
endinterface

interface ssh_result_if;
  logic                             valid;
  logic                             ready;
  logic [ssh_pkg::KIND_W-1:0]       kind;
  logic signed [ssh_pkg::VAL_W-1:0] value;
  logic                             last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

FILE: rtl/sweep_sensor_homing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sweep_sensor_homing: sensor-sweep homing controller for one stepper axis
// Config registers, microcode sequencer, datapath and remainder unit.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready input. op 0 begins homing with the absolute position,
//            op 1 is a sensor sample (level and stepper position), op 2 says
//            the last commanded move has finished.
//   result : valid/ready output of (kind, value, last); last marks the final
//            result caused by an item. An item causes zero, one or two results.
//   cfg    : write port (cfg_we, cfg_index, cfg_data); write only while idle.
// Timing: one microcode step per cycle while the sequencer does not hold. A
//   begin waits for the remainder unit, which resolves one dividend bit per
//   cycle. Results are registered and appear in the cycle after their step;
//   one item is handled at a time.
// Stall: a single output register holds the pending result. The next item is
//   accepted while it waits; the sequencer holds only at a step that must
//   emit while the register is still full, and nothing is dropped.
// Reset: rst (synchronous) returns to idle with the register defaults
//   (3200 steps, width 100, secondary set) and an empty output register.
// ----------------------------------------------------------------------------
module sweep_sensor_homing #(
  parameter int POS_BITS = ssh_pkg::POS_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ssh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssh_pkg::CFG_DATA_W-1:0]   cfg_data,
  ssh_item_if.sink                         item,
  ssh_result_if.source                     result
);

  ssh_pkg::cfg_t                    cfg;
  ssh_pkg::ctl_t                    ctl;
  ssh_pkg::stat_t                   stat;
  logic                             div_start;
  logic signed [POS_BITS-1:0]       div_dividend;
  logic                             div_done;
  logic signed [ssh_pkg::REM_W-1:0] div_rem;

  // Configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rev_steps    <= ssh_pkg::REV_STEPS_RST;
      cfg.sensor_width <= ssh_pkg::SENSOR_WIDTH_RST;
      cfg.is_secondary <= ssh_pkg::IS_SECONDARY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssh_pkg::REG_REV_STEPS:    cfg.rev_steps    <= cfg_data;
        ssh_pkg::REG_SENSOR_WIDTH: cfg.sensor_width <= cfg_data[ssh_pkg::SW_W-1:0];
        ssh_pkg::REG_IS_SECONDARY: cfg.is_secondary <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  ssh_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  ssh_div #(
    .POS_BITS (POS_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cfg.rev_steps),
    .done     (div_done),
    .rem      (div_rem)
  );

  ssh_dp #(
    .POS_BITS (POS_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .ctl          (ctl),
    .stat         (stat),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_done     (div_done),
    .div_rem      (div_rem),
    .item         (item),
    .result       (result)
  );

endmodule

FILE: rtl/ssh_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssh_seq: microcode sequencer
// Steps a program counter through the control store, holds on wait steps and
// takes conditional jumps from datapath status.
// ----------------------------------------------------------------------------
module ssh_seq (
  input  logic           clk,
  input  logic           rst,
  input  ssh_pkg::stat_t stat,
  output ssh_pkg::ctl_t  ctl
);

  ssh_pkg::addr_t  upc;
  ssh_pkg::addr_t  upc_next;
  ssh_pkg::uword_t word;
  logic            hit;
  logic            stall;

  // Look up the current control word
  assign word = ssh_pkg::ucode_rom(upc);

  // Evaluate the jump condition
  always_comb begin
    unique case (word.cond)
      ssh_pkg::C_NEVER:     hit = 1'b0;
      ssh_pkg::C_ALWAYS:    hit = 1'b1;
      ssh_pkg::C_OP_BEGIN:  hit = stat.op_begin;
      ssh_pkg::C_SKIP:      hit = stat.skip;
      ssh_pkg::C_OP_SAMPLE: hit = stat.op_sample;
      ssh_pkg::C_PASS_LT:   hit = stat.pass_lt;
      ssh_pkg::C_WIDTH_BAD: hit = stat.width_bad;
      ssh_pkg::C_MEAS_OK:   hit = stat.meas_ok;
      ssh_pkg::C_REV_ZERO:  hit = stat.rev_zero;
      ssh_pkg::C_PRIMARY:   hit = stat.primary;
      default:              hit = 1'b0;
    endcase
  end

  // Hold on fetch, on the remainder unit and on a full output register
  always_comb begin
    unique case (word.act)
      ssh_pkg::A_FETCH:    stall = !stat.in_fire;
      ssh_pkg::A_DIV_WAIT: stall = !stat.div_done;
      default:             stall = word.emit && !stat.out_free;
    endcase
  end

  assign ctl.word = word;
  assign ctl.go   = !stall;

  // Advance or jump
  always_comb begin
    if (stall) begin
      upc_next = upc;
    end else if (hit) begin
      upc_next = word.target;
    end else begin
      upc_next = ssh_pkg::addr_t'(upc + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ssh_pkg::ADDR_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

FILE: rtl/ssh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssh_div: remainder unit
// Restoring division of a signed position by the revolution length, one
// dividend bit per cycle; the remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module ssh_div #(
  parameter int POS_BITS = ssh_pkg::POS_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [POS_BITS-1:0]       dividend,
  input  logic [ssh_pkg::REV_W-1:0]        divisor,
  output logic                             done,
  output logic signed [ssh_pkg::REM_W-1:0] rem
);

  localparam int CNT_W = $clog2(POS_BITS + 1);
  localparam int RW    = ssh_pkg::REV_W;
  localparam int MW    = ssh_pkg::REM_W;

  logic [CNT_W-1:0]     cnt;
  logic [POS_BITS-1:0]  mag;
  logic [RW-1:0]        part;
  logic [RW-1:0]        dsr;
  logic                 neg;
  logic [RW:0]          trial;
  logic                 fits;
  logic signed [MW-1:0] rem_mag;

  // Shift in the next dividend bit and try a subtract
  assign trial   = {part, mag[POS_BITS-1]};
  assign fits    = trial >= {1'b0, dsr};
  assign done    = (cnt == '0);
  assign rem_mag = $signed({1'b0, part});
  assign rem     = neg ? -rem_mag : rem_mag;

  // Count the remaining bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(POS_BITS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Load operands, then iterate
  always_ff @(posedge clk) begin
    if (start) begin
      mag  <= dividend[POS_BITS-1] ? $unsigned(-dividend) : $unsigned(dividend);
      part <= '0;
      dsr  <= divisor;
      neg  <= dividend[POS_BITS-1];
    end else if (cnt != '0) begin
      mag  <= {mag[POS_BITS-2:0], 1'b0};
      part <= fits ? RW'(trial - {1'b0, dsr}) : trial[RW-1:0];
    end
  end

endmodule

FILE: rtl/ssh_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssh_dp: homing datapath
// Item latch, homing state, sweep target and centre arithmetic, width checks
// and the result register, all driven by the current control word.
// ----------------------------------------------------------------------------
module ssh_dp #(
  parameter int POS_BITS = ssh_pkg::POS_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ssh_pkg::cfg_t                    cfg,
  input  ssh_pkg::ctl_t                    ctl,
  output ssh_pkg::stat_t                   stat,
  output logic                             div_start,
  output logic signed [POS_BITS-1:0]       div_dividend,
  input  logic                             div_done,
  input  logic signed [ssh_pkg::REM_W-1:0] div_rem,
  ssh_item_if.sink                         item,
  ssh_result_if.source                     result
);

  localparam int VW  = ssh_pkg::VAL_W;
  localparam int AW  = ssh_pkg::ARITH_W;
  localparam int PW  = POS_BITS + 1;
  localparam int PSW = ssh_pkg::PASS_W;
  localparam int SPW = ssh_pkg::SPAN_W;
  localparam int RW  = ssh_pkg::REV_W;
  localparam int SWW = ssh_pkg::SW_W;
  localparam int FW  = ssh_pkg::REM_W + 1;
  localparam int MUL_W = RW - 3 + PSW;

  // Latched item
  logic [ssh_pkg::OP_W-1:0]   op_q;
  logic signed [POS_BITS-1:0] pos_q;
  logic                       lvl_q;

  // Homing state
  logic                       active;
  logic [PSW-1:0]             pass_index;
  logic signed [POS_BITS-1:0] fold_offset;
  logic                       prev_level;
  logic                       edge_seen;
  logic signed [POS_BITS-1:0] edge_start;
  logic signed [POS_BITS-1:0] last_width;
  logic                       meas;
  logic [SPW-1:0]             span;

  // Result register
  logic                          out_valid;
  logic [ssh_pkg::KIND_W-1:0]    out_kind;
  logic signed [POS_BITS-1:0]    out_value;
  logic                          out_last;

  logic                       fire_in;
  logic                       fetch;
  logic                       rise;
  logic                       fall;
  logic signed [POS_BITS-1:0] diff;
  logic [POS_BITS-1:0]        lw_abs;
  logic [SWW+2:0]             w3;
  logic [SWW+2:0]             w5;
  logic [SWW:0]               lo;
  logic [SWW:0]               hi;
  logic                       width_ok;
  logic                       gt_min;
  logic [PSW:0]               k_sum;
  logic [PSW-1:0]             k;
  logic [MUL_W-1:0]           prod;
  logic [SPW-1:0]             span_calc;
  logic signed [AW-1:0]       fold_w;
  logic signed [AW-1:0]       span_w;
  logic signed [AW-1:0]       tgt_w;
  logic signed [POS_BITS-1:0] target;
  logic signed [PW-1:0]       lw_ext;
  logic signed [PW-1:0]       lw_half;
  logic signed [PW-1:0]       ctr_w;
  logic signed [POS_BITS-1:0] centre;
  logic signed [FW-1:0]       mod_e;
  logic signed [FW-1:0]       half_e;
  logic signed [FW-1:0]       rev_e;
  logic signed [FW-1:0]       adj;
  logic signed [POS_BITS-1:0] fold_val;
  logic signed [POS_BITS-1:0] emit_value;

  // Input handshake: ready only on the fetch step
  assign fetch      = (ctl.word.act == ssh_pkg::A_FETCH);
  assign item.ready = fetch;
  assign fire_in    = item.valid && fetch;

  // Result port
  assign result.valid = out_valid;
  assign result.kind  = out_kind;
  assign result.value = VW'(out_value);
  assign result.last  = out_last;

  // Remainder unit hookup
  assign div_start    = ctl.go && (ctl.word.act == ssh_pkg::A_BEGIN);
  assign div_dividend = pos_q;

  // Sensor edges and measured width
  assign rise = lvl_q && !prev_level;
  assign fall = !lvl_q && prev_level;
  assign diff = pos_q - edge_start;

  // Width window: strictly between 3/4 and 5/4 of the expected width
  assign lw_abs   = last_width[POS_BITS-1] ? $unsigned(-last_width) : $unsigned(last_width);
  assign w3       = {3'b000, cfg.sensor_width} + {2'b00, cfg.sensor_width, 1'b0};
  assign w5       = {3'b000, cfg.sensor_width} + {1'b0, cfg.sensor_width, 2'b00};
  assign lo       = w3[SWW+2:2];
  assign hi       = w5[SWW+2:2];
  assign width_ok = (lw_abs > POS_BITS'(lo)) && (lw_abs < POS_BITS'(hi));
  assign gt_min   = lw_abs > POS_BITS'(ssh_pkg::MIN_WIDTH);

  // Sweep span: rev/8 times half the pass index rounded up, plus twice the sensor width
  assign k_sum     = {1'b0, pass_index} + 1'b1;
  assign k         = k_sum[PSW:1];
  assign prod      = cfg.rev_steps[RW-1:3] * k;
  assign span_calc = SPW'(prod) + SPW'({cfg.sensor_width, 1'b0});

  // Target: odd passes go positive, even passes negative
  assign fold_w = AW'(fold_offset);
  assign span_w = AW'(span);
  assign tgt_w  = pass_index[0] ? fold_w + span_w : fold_w - span_w;
  assign target = tgt_w[POS_BITS-1:0];

  // Centre: start plus half the width, rounded toward zero
  assign lw_ext  = PW'(last_width) + PW'(last_width[POS_BITS-1]);
  assign lw_half = lw_ext >>> 1;
  assign ctr_w   = PW'(edge_start) + lw_half;
  assign centre  = ctr_w[POS_BITS-1:0];

  // Fold the remainder into a signed offset around zero
  assign mod_e    = FW'(div_rem);
  assign half_e   = {3'b000, cfg.rev_steps[RW-1:1]};
  assign rev_e    = {2'b00, cfg.rev_steps};
  assign adj      = (mod_e > half_e) ? mod_e - rev_e : mod_e;
  assign fold_val = (cfg.rev_steps == '0) ? pos_q : POS_BITS'(adj);

  // Select the value for an emit step
  always_comb begin
    unique case (ctl.word.act)
      ssh_pkg::A_EMIT_FOLD:   emit_value = fold_offset;
      ssh_pkg::A_EMIT_TARGET: emit_value = target;
      ssh_pkg::A_EMIT_CENTRE: emit_value = centre;
      default:                emit_value = '0;
    endcase
  end

  // Status for the sequencer
  always_comb begin
    stat.in_fire   = fire_in;
    stat.div_done  = div_done;
    stat.out_free  = !out_valid || result.ready;
    stat.op_begin  = (op_q == ssh_pkg::OP_BEGIN);
    stat.op_sample = (op_q == ssh_pkg::OP_SAMPLE);
    stat.skip      = !active || (op_q == ssh_pkg::OP_RSVD);
    stat.pass_lt   = pass_index < PSW'(ssh_pkg::SWEEPS);
    stat.width_bad = !width_ok;
    stat.meas_ok   = meas && gt_min && width_ok;
    stat.rev_zero  = (cfg.rev_steps == '0);
    stat.primary   = !cfg.is_secondary;
  end

  // Homing state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      pass_index  <= '0;
      fold_offset <= '0;
      prev_level  <= 1'b0;
      edge_seen   <= 1'b0;
      edge_start  <= '0;
      last_width  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.go) begin
        unique case (ctl.word.act)
          ssh_pkg::A_BEGIN: begin
            edge_seen  <= 1'b0;
            edge_start <= '0;
            prev_level <= lvl_q;
            active     <= 1'b1;
            pass_index <= PSW'(1);
          end
          ssh_pkg::A_FOLD: begin
            fold_offset <= fold_val;
          end
          ssh_pkg::A_PASS_INC: begin
            pass_index <= pass_index + 1'b1;
          end
          ssh_pkg::A_EDGE: begin
            if (rise) begin
              edge_seen  <= 1'b1;
              edge_start <= pos_q;
            end
            if (fall && edge_seen) begin
              last_width <= diff;
            end
            prev_level <= lvl_q;
          end
          ssh_pkg::A_FINISH: begin
            edge_seen <= 1'b0;
            active    <= 1'b0;
          end
          ssh_pkg::A_QUIT: begin
            active <= 1'b0;
          end
          default: begin
          end
        endcase
        if (ctl.word.emit) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  // Item latch, span, measurement flag and result payload
  always_ff @(posedge clk) begin
    if (fire_in) begin
      op_q  <= item.op;
      pos_q <= $signed(item.position[POS_BITS-1:0]);
      lvl_q <= item.sensor;
    end
    if (ctl.go && (ctl.word.act == ssh_pkg::A_SPAN)) begin
      span <= span_calc;
    end
    if (ctl.go && (ctl.word.act == ssh_pkg::A_EDGE)) begin
      meas <= fall && edge_seen;
    end
    if (ctl.go && ctl.word.emit) begin
      out_kind  <= ctl.word.kind;
      out_value <= emit_value;
      out_last  <= ctl.word.last;
    end
  end

endmodule

FILE: rtl/ssh_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssh_chk: port checker for the sweep homing block
// Watches the item and result channels of the top level.
// ----------------------------------------------------------------------------
module ssh_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             item_valid,
  input logic                             item_ready,
  input logic                             result_valid,
  input logic                             result_ready,
  input logic [ssh_pkg::KIND_W-1:0]       result_kind,
  input logic signed [ssh_pkg::VAL_W-1:0] result_value,
  input logic                             result_last
);

  // A stalled result holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_kind) && $stable(result_value) && $stable(result_last))
    else $error("result changed while stalled");

  // Ready drops in the cycle after each item transfer
  a_item_gap: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item ready held after a transfer");

  // Moves and home close an item; set-position and centre never do
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result_last == ((result_kind == ssh_pkg::KIND_MOVE) ||
                       (result_kind == ssh_pkg::KIND_HOME))))
    else $error("last flag does not match result kind");

  // A centre transfer is followed at once by the home result
  a_centre_home: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && (result_kind == ssh_pkg::KIND_CENTRE) |=>
      result_valid && (result_kind == ssh_pkg::KIND_HOME) && result_last)
    else $error("centre result not followed by home");

endmodule

bind sweep_sensor_homing ssh_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_kind  (result.kind),
  .result_value (result.value),
  .result_last  (result.last)
);
